[hdl/csqe_pkg.sv]
// Shared constants, escape kind codes and helper functions for the quote escaper.
package csqe_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SEQ_N  = 4;
  localparam int unsigned CNT_W  = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [SEQ_N-1:0][BYTE_W-1:0] seq_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [2:0] kind_t;

  localparam byte_t CTL_LIMIT = 8'd30;
  localparam byte_t CH_BSLASH = 8'd92;
  localparam byte_t CH_DQUOTE = 8'd34;
  localparam byte_t CH_SQUOTE = 8'd39;
  localparam byte_t CH_NL     = 8'd10;
  localparam byte_t CH_TAB    = 8'd9;
  localparam byte_t CH_CR     = 8'd13;
  localparam byte_t CH_N      = 8'd110;
  localparam byte_t CH_T      = 8'd116;
  localparam byte_t CH_R      = 8'd114;
  localparam byte_t CH_X      = 8'd120;

  // escape kinds, decided at the input stage
  localparam kind_t K_PASS  = 3'd0;
  localparam kind_t K_NL    = 3'd1;
  localparam kind_t K_TAB   = 3'd2;
  localparam kind_t K_CR    = 3'd3;
  localparam kind_t K_BSL   = 3'd4;
  localparam kind_t K_QUOTE = 3'd5;
  localparam kind_t K_HEX   = 3'd6;

  // configuration register index
  localparam logic REG_QUOTE = 1'b0;

  function automatic byte_t hex_digit(input logic [3:0] v);
    byte_t r;
    if (v < 4'd10) begin
      r = 8'd48 + {4'd0, v};
    end else begin
      r = 8'd87 + {4'd0, v};
    end
    return r;
  endfunction

  function automatic kind_t classify(input byte_t b, input byte_t q);
    kind_t k;
    if (b == CH_NL) begin
      k = K_NL;
    end else if (b == CH_TAB) begin
      k = K_TAB;
    end else if (b == CH_CR) begin
      k = K_CR;
    end else if (b == CH_BSLASH) begin
      k = K_BSL;
    end else if ((q != 8'd0) && (b == q)) begin
      k = K_QUOTE;
    end else if ((q == 8'd0) && ((b == CH_DQUOTE) || (b == CH_SQUOTE))) begin
      k = K_QUOTE;
    end else if (b < CTL_LIMIT) begin
      k = K_HEX;
    end else begin
      k = K_PASS;
    end
    return k;
  endfunction

endpackage

[hdl/c_string_quote_escaper_unit.sv]
// Top level of the C string quote escaper: classify, expand and serialize stages.
//
//  channel | dir | handshake                      | payload
//  --------+-----+--------------------------------+----------------------------------
//  in_     | in  | in_tvalid / in_tready          | tdata = in_byte, tlast = in_end
//  out_    | out | out_tvalid / out_tready        | tdata = out_byte, tlast = run_last,
//          |     |                                | tuser = out_end
//  cfg_    | in  | APB psel/penable, pready high  | reg 0 at byte address 0: quote_char
//
// Three register stages: classify (stage 1), build the escape sequence (stage 2),
// serialize it (stage 3, which also is the output register). A byte that passes
// through costs one output beat, an escaped one two, a hex escape four; the
// serializer in stage 3 sets the rate, so the input runs at one beat per cycle
// while output bytes do.
// Synchronous active-low reset clears the valid bits and quote_char. A stall at
// out_tready holds every stage that is full; empty stages still fill.
module c_string_quote_escaper_unit (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_end
  // output stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // run_last
  output logic       out_tuser,  // [0] out_end
  // configuration port
  input  logic       cfg_psel,
  input  logic       cfg_penable,
  input  logic       cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready
);

  // ---------------------------------------------------------------- config
  csqe_pkg::byte_t quote_r;
  logic            cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r <= 8'd0;
    end else if (cfg_wr && (cfg_paddr[2] == csqe_pkg::REG_QUOTE)) begin
      quote_r <= cfg_pwdata[7:0];
    end
  end

  // only one register; everything past it reads as zero
  assign cfg_prdata = (cfg_paddr[2] == csqe_pkg::REG_QUOTE) ? {24'd0, quote_r} : 32'd0;

  // ------------------------------------------------------- stage handshakes
  logic s1_vld_r, s2_vld_r, s3_vld_r;
  logic s1_rdy, s2_rdy, s3_rdy;
  logic out_beat, s3_last;

  csqe_pkg::cnt_t  s3_cnt_r;  // beats remaining after the current one

  assign s3_last  = (s3_cnt_r == '0);
  assign out_beat = s3_vld_r & out_tready;
  // stage 3 frees up on the final beat of its run
  assign s3_rdy   = ~s3_vld_r | (out_beat & s3_last);
  assign s2_rdy   = ~s2_vld_r | s3_rdy;
  assign s1_rdy   = ~s1_vld_r | s2_rdy;
  assign in_tready = s1_rdy;

  // ------------------------------------------------------ stage 1: classify
  csqe_pkg::byte_t s1_byte_r;
  csqe_pkg::kind_t s1_kind_r;
  logic            s1_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_end_r  <= in_tlast;
      s1_kind_r <= csqe_pkg::classify(in_tdata, quote_r);
    end
  end

  // ------------------------------------------------ stage 2: build sequence
  csqe_pkg::seq_t s2_seq_r, s2_seq_nxt;
  csqe_pkg::cnt_t s2_cnt_r, s2_cnt_nxt;
  logic           s2_end_r;

  always_comb begin
    s2_seq_nxt = '0;
    s2_cnt_nxt = 2'd1;
    s2_seq_nxt[0] = csqe_pkg::CH_BSLASH;
    case (s1_kind_r)
      csqe_pkg::K_NL:    s2_seq_nxt[1] = csqe_pkg::CH_N;
      csqe_pkg::K_TAB:   s2_seq_nxt[1] = csqe_pkg::CH_T;
      csqe_pkg::K_CR:    s2_seq_nxt[1] = csqe_pkg::CH_R;
      csqe_pkg::K_BSL:   s2_seq_nxt[1] = csqe_pkg::CH_BSLASH;
      csqe_pkg::K_QUOTE: s2_seq_nxt[1] = s1_byte_r;
      csqe_pkg::K_HEX: begin
        s2_seq_nxt[1] = csqe_pkg::CH_X;
        s2_seq_nxt[2] = csqe_pkg::hex_digit(s1_byte_r[7:4]);
        s2_seq_nxt[3] = csqe_pkg::hex_digit(s1_byte_r[3:0]);
        s2_cnt_nxt    = 2'd3;
      end
      default: begin
        // plain byte: single beat
        s2_seq_nxt[0] = s1_byte_r;
        s2_cnt_nxt    = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_vld_r) begin
      s2_seq_r <= s2_seq_nxt;
      s2_cnt_r <= s2_cnt_nxt;
      s2_end_r <= s1_end_r;
    end
  end

  // --------------------------------------------------- stage 3: serializer
  csqe_pkg::seq_t s3_seq_r;
  logic           s3_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_vld_r) begin
      // load the next run straight behind the final beat of this one
      s3_seq_r <= s2_seq_r;
      s3_cnt_r <= s2_cnt_r;
      s3_end_r <= s2_end_r;
    end else if (out_beat && !s3_last) begin
      // advance: shift the next byte of the run to the front
      s3_seq_r <= {8'd0, s3_seq_r[3:1]};
      s3_cnt_r <= s3_cnt_r - 2'd1;
    end
  end

  assign out_tvalid = s3_vld_r;
  assign out_tdata  = s3_seq_r[0];
  assign out_tlast  = s3_last;
  assign out_tuser  = s3_end_r & s3_last;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the C string quote escaper unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected output beat: the escaped byte, the end-of-run flag and the string end.
  typedef struct packed {
    csqe_pkg::byte_t ch;
    logic            run_last;
    logic            str_end;
  } esc_beat_t;

  // Digits of the hex escape, as ASCII
  localparam csqe_pkg::byte_t CH_ZERO    = 8'd48;
  localparam csqe_pkg::byte_t CH_LOWER_A = 8'd97;

  // Register index to byte address: 4 bytes per register
  localparam logic [2:0] QUOTE_ADDR = {csqe_pkg::REG_QUOTE, 2'b00};

  // Padding after the owed beats run out, to let the pipe settle
  localparam int unsigned SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;      // [7:0] in_byte
  logic        in_tlast = 1'b0;    // in_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // [7:0] out_byte
  logic        out_tlast;          // run_last
  logic        out_tuser;          // [0] out_end
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Our own copy of the quote register and the beats still owed by the block
  csqe_pkg::byte_t quote_q = 8'd0;
  esc_beat_t       escaped_q[$];
  int unsigned     err_cnt = 0;

  // Idle shaping: percent chance of a gap / stall burst, and a switch that turns both off
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          quiet = 1'b0;

  c_string_quote_escaper_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Escape predictor
  // ---------------------------------------------------------------------------

  function automatic csqe_pkg::byte_t hex_char(input logic [3:0] v);
    return (v < 4'd10) ? csqe_pkg::byte_t'(CH_ZERO + v)
                       : csqe_pkg::byte_t'(CH_LOWER_A + (v - 4'd10));
  endfunction

  // Work out the escaped run for one text byte and queue its beats.
  // Rules are tried in order: newline, tab, CR, backslash, the configured
  // quote (nonzero setting), either quote (zero setting), other control, pass.
  function automatic void predict_escape(input csqe_pkg::byte_t c, input logic fin);
    csqe_pkg::byte_t seq [4];
    int              n;
    esc_beat_t       b;
    seq[0] = csqe_pkg::CH_BSLASH;
    n = 2;
    if (c == csqe_pkg::CH_NL) begin
      seq[1] = csqe_pkg::CH_N;
    end else if (c == csqe_pkg::CH_TAB) begin
      seq[1] = csqe_pkg::CH_T;
    end else if (c == csqe_pkg::CH_CR) begin
      seq[1] = csqe_pkg::CH_R;
    end else if (c == csqe_pkg::CH_BSLASH) begin
      seq[1] = csqe_pkg::CH_BSLASH;
    end else if (quote_q != 8'd0 && c == quote_q) begin
      // a quote below the control limit still goes out as itself, not in hex
      seq[1] = quote_q;
    end else if (quote_q == 8'd0 &&
                 (c == csqe_pkg::CH_DQUOTE || c == csqe_pkg::CH_SQUOTE)) begin
      seq[1] = c;
    end else if (c < csqe_pkg::CTL_LIMIT) begin
      seq[1] = csqe_pkg::CH_X;
      seq[2] = hex_char(c[7:4]);
      seq[3] = hex_char(c[3:0]);
      n = 4;
    end else begin
      // plain byte, including everything above 127
      seq[0] = c;
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      b.ch       = seq[k];
      b.run_last = (k == n - 1);
      b.str_end  = (k == n - 1) && fin;
      escaped_q.push_back(b);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready shaping and the beat checker
  // ---------------------------------------------------------------------------

  // Hold out_tready low in random bursts; never toggle twice in one step.
  initial begin : sink_ready
    int n;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 15);
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
    end
  end

  // Compare each accepted output beat against the oldest expectation.
  // Everything is sampled at the edge, before any nonblocking update lands.
  always @(posedge clk) begin : beat_check
    esc_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (escaped_q.size() == 0) begin
        $display("%0t: unexpected beat byte=%02h run_last=%0b end=%0b",
                 $time, out_tdata, out_tlast, out_tuser);
        err_cnt++;
      end else begin
        want = escaped_q.pop_front();
        if (out_tdata !== want.ch) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.ch, out_tdata);
          err_cnt++;
        end
        if (out_tlast !== want.run_last) begin
          $display("%0t: run_last expected %0b actual %0b",
                   $time, want.run_last, out_tlast);
          err_cnt++;
        end
        if (out_tuser !== want.str_end) begin
          $display("%0t: out_end expected %0b actual %0b", $time, want.str_end, out_tuser);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side and configuration tasks; all are entered just after a rising edge
  // ---------------------------------------------------------------------------

  // Offer one text byte and hold it until the block takes it. Unless a random gap
  // was taken, in_tvalid stays high on return so back-to-back beats need no toggle.
  task automatic send_char(input csqe_pkg::byte_t c, input logic fin);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    predict_escape(c, fin);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every owed beat has come out, then let the pipe settle.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic reg_read(input logic [2:0] addr, output logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    data = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Read the quote register back and compare its byte.
  task automatic check_quote_reg;
    logic [31:0] rd;
    reg_read(QUOTE_ADDR, rd);
    if (rd[7:0] !== quote_q) begin
      $display("%0t: quote_char readback expected %02h actual %02h", $time, quote_q, rd[7:0]);
      err_cnt++;
    end
  endtask

  // Change the quote byte only with the block empty.
  task automatic set_quote(input csqe_pkg::byte_t q);
    drain();
    reg_write(QUOTE_ADDR, {24'd0, q});
    quote_q = q;
    // idle between the write and the readback transfer
    @(posedge clk);
    check_quote_reg();
  endtask

  // Weighted random text: lean on control bytes, escapes and the live quote.
  function automatic csqe_pkg::byte_t rand_char;
    csqe_pkg::byte_t c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = csqe_pkg::byte_t'($urandom_range(0, 255));
      3:       c = csqe_pkg::byte_t'($urandom_range(0, 31));
      4: begin
        case ($urandom_range(0, 5))
          0: c = csqe_pkg::CH_NL;
          1: c = csqe_pkg::CH_TAB;
          2: c = csqe_pkg::CH_CR;
          3: c = csqe_pkg::CH_BSLASH;
          4: c = csqe_pkg::CH_DQUOTE;
          default: c = csqe_pkg::CH_SQUOTE;
        endcase
      end
      5:       c = quote_q;
      6:       c = csqe_pkg::byte_t'($urandom_range(30, 127));
      7:       c = csqe_pkg::byte_t'($urandom_range(128, 255));
      default: c = csqe_pkg::byte_t'($urandom_range(0, 63));
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The register comes out of reset as zero.
  task automatic test_reset_value;
    check_quote_reg();
  endtask

  // Zero quote setting: every escape kind, the control boundary and byte extremes.
  task automatic test_escape_kinds;
    gap_pct   = 30;
    stall_pct = 30;
    send_char(8'h00, 1'b0);
    send_char(csqe_pkg::CH_TAB, 1'b0);
    send_char(csqe_pkg::CH_NL, 1'b0);
    send_char(csqe_pkg::CH_CR, 1'b1);
    send_char(8'h1D, 1'b0);    // last byte below the limit, hex form
    send_char(csqe_pkg::CTL_LIMIT, 1'b0); // first byte that passes
    send_char(8'h1F, 1'b0);
    send_char(csqe_pkg::CH_DQUOTE, 1'b0);
    send_char(csqe_pkg::CH_SQUOTE, 1'b1);
    send_char(csqe_pkg::CH_BSLASH, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'h0F, 1'b0);
    send_char(8'h10, 1'b1);
  endtask

  // Nonzero quote settings: the chosen byte only, low quotes, and overlaps with other rules.
  task automatic test_quote_settings;
    set_quote(8'hFF);
    send_char(8'hFF, 1'b0);
    send_char(csqe_pkg::CH_DQUOTE, 1'b0); // other quotes pass unchanged now
    send_char(csqe_pkg::CH_SQUOTE, 1'b1);
    set_quote(8'h05);           // control-range quote: backslash plus the byte, no hex
    send_char(8'h05, 1'b1);
    set_quote(csqe_pkg::CH_BSLASH);       // backslash quote is just doubled
    send_char(csqe_pkg::CH_BSLASH, 1'b1);
    set_quote(csqe_pkg::CH_NL);           // newline rule wins over the quote
    send_char(csqe_pkg::CH_NL, 1'b1);
    set_quote(csqe_pkg::CH_DQUOTE);
    send_char(csqe_pkg::CH_DQUOTE, 1'b0);
    send_char(csqe_pkg::CH_SQUOTE, 1'b1);
  endtask

  // Random strings under several quote settings and idle mixes.
  task automatic test_random_text;
    csqe_pkg::byte_t q;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: q = 8'd0;
        1: q = 8'hFF;
        2: q = csqe_pkg::CH_SQUOTE;
        3: q = csqe_pkg::byte_t'($urandom_range(1, 29));
        default: q = csqe_pkg::byte_t'($urandom_range(1, 254));
      endcase
      set_quote(q);
      gap_pct   = (ph == 2) ? 0 : $urandom_range(10, 60);
      stall_pct = (ph == 3) ? 0 : $urandom_range(10, 60);
      for (int i = 0; i < 30; i++) begin
        send_char(rand_char(), ($urandom_range(0, 7) == 0));
        // hold off the sender once until the output side has fully caught up
        if (ph == 1 && i == 17) drain();
      end
    end
  endtask

  // Tail of the run: no gaps, no stalls, full rate.
  task automatic test_full_rate;
    set_quote(8'd0);
    quiet = 1'b1;
    for (int i = 0; i < 35; i++) begin
      send_char(rand_char(), ($urandom_range(0, 5) == 0));
    end
  endtask

  initial begin : main_seq
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_value();
    test_escape_kinds();
    test_quote_settings();
    test_random_text();
    test_full_rate();

    // Drop valid, wait out everything owed, then wait SETTLE_CYCLES for stray beats
    in_tvalid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
